// File: rtl/core/pbu_pkg.sv
// Shared blend-mode codes, lane result selectors and widths for the pixel blend unit.
package pbu_pkg;

    localparam int PIX_W   = 8;
    localparam int PROD_W  = 2 * PIX_W;
    localparam int MAX_CH  = 3;

    typedef enum logic [2:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SCREEN   = 3'd1,
        MODE_SUBTRACT = 3'd2,
        MODE_ADD      = 3'd3,
        MODE_OVERLAY  = 3'd4
    } blend_mode_t;

    // How the second lane stage forms the channel byte.
    typedef enum logic [1:0] {
        SEL_DIV     = 2'd0,
        SEL_INV_DIV = 2'd1,
        SEL_DIRECT  = 2'd2,
        SEL_ZERO    = 2'd3
    } res_sel_t;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

// File: rtl/core/pbu_lane.sv
// One color channel blend lane: operand select and multiply (or a direct subtract/add result), then divide by 255.
module pbu_lane
    import pbu_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic [2:0]       func,
    input  pix_t             a,
    input  pix_t             b,
    output pix_t             res
);

    pix_t              ia;
    pix_t              ib;
    pix_t              op_a;
    pix_t              op_b;
    logic              dbl;
    logic [PROD_W-1:0] prod;
    logic [PIX_W:0]    sum;
    pix_t              direct_next;
    res_sel_t          sel_next;
    logic [PROD_W-1:0] prod_next;

    logic [PROD_W-1:0] prod_reg;
    res_sel_t          sel_reg;
    pix_t              direct_reg;

    logic [PROD_W-1:0] biased;
    logic [PROD_W-1:0] scaled;
    pix_t              quot;

    assign ia  = ~a;
    assign ib  = ~b;
    assign sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        op_a        = a;
        op_b        = b;
        dbl         = 1'b0;
        direct_next = '0;
        sel_next    = SEL_ZERO;
        unique case (func)
            MODE_MULTIPLY:
            begin
                sel_next = SEL_DIV;
            end
            MODE_SCREEN:
            begin
                op_a     = ia;
                op_b     = ib;
                sel_next = SEL_INV_DIV;
            end
            MODE_SUBTRACT:
            begin
                direct_next = (a > b) ? (a - b) : '0;
                sel_next    = SEL_DIRECT;
            end
            MODE_ADD:
            begin
                direct_next = sum[PIX_W] ? '1 : sum[PIX_W-1:0];
                sel_next    = SEL_DIRECT;
            end
            MODE_OVERLAY:
            begin
                dbl = 1'b1;
                if (b[PIX_W-1])
                begin
                    op_a     = ia;
                    op_b     = ib;
                    sel_next = SEL_INV_DIV;
                end
                else
                begin
                    sel_next = SEL_DIV;
                end
            end
            default:
            begin
                sel_next = SEL_ZERO;
            end
        endcase
    end

    // In overlay mode one operand is below half scale, so the doubled product still fits.
    assign prod      = op_a * op_b;
    assign prod_next = dbl ? {prod[PROD_W-2:0], 1'b0} : prod;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg   <= prod_next;
            sel_reg    <= sel_next;
            direct_reg <= direct_next;
        end
    end

    // Rounded division by 255: q = (y + (y >> 8) + 1) >> 8 with y = x + 127, exact for this range.
    assign biased = prod_reg + PROD_W'(127);
    assign scaled = biased + {{PIX_W{1'b0}}, biased[PROD_W-1:PIX_W]} + PROD_W'(1);
    assign quot   = scaled[PROD_W-1:PIX_W];

    always_comb
    begin
        unique case (sel_reg)
            SEL_DIV:     res = quot;
            SEL_INV_DIV: res = ~quot;
            SEL_DIRECT:  res = direct_reg;
            SEL_ZERO:    res = '0;
            default:     res = '0;
        endcase
    end

endmodule

// File: rtl/core/pbu_merge.sv
// Output stage that gathers the lane results into one registered pixel beat.
module pbu_merge
    import pbu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              lane_valid,
    input  pix_t [MAX_CH-1:0] lane_res,
    input  logic              out_stall,
    output logic              ready,
    output logic              out_valid,
    output pix_t              out_red,
    output pix_t              out_green,
    output pix_t              out_blue
);

    logic out_valid_reg;
    logic out_valid_next;
    logic load;
    pix_t red_reg;
    pix_t green_reg;
    pix_t blue_reg;

    assign ready          = !out_valid_reg || !out_stall;
    assign load           = lane_valid && ready;
    assign out_valid_next = ready ? lane_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= lane_res[0];
            green_reg <= lane_res[1];
            blue_reg  <= lane_res[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

// File: rtl/core/pixel_blend_unit.sv
// Top level of the pixel blend unit: per-channel lanes feeding a registered output stage.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  func, top_red/green/blue, bottom_red/green/blue
//   output    out_valid/out_stall  out_red, out_green, out_blue
//
// One pixel beat is accepted every cycle while in_stall is low; its result passes
// through the lane multiplier register and then the output register.
// Reset (rst_n, asynchronous, active low) clears only the stage valid flags.
// When the output is stalled the held beat stays put, and one more beat still
// enters the lane stage; in_stall rises only once both stages are full.
//
// Each lane blends one color channel. The first stage picks the operands for
// the mode (the byte or its complement), runs one 8x8 multiply and doubles it
// for overlay; subtract and add are finished there directly. The second stage
// rounds the product divided by 255 with a shift-and-add reciprocal and
// complements it for the screen-like cases. Only the first CHANNELS channels
// get a lane, in red, green, blue order; the rest read as zero.
module pixel_blend_unit
    import pbu_pkg::*;
#(
    parameter int CHANNELS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  logic [7:0] top_red,
    input  logic [7:0] top_green,
    input  logic [7:0] top_blue,
    input  logic [7:0] bottom_red,
    input  logic [7:0] bottom_green,
    input  logic [7:0] bottom_blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue
);

    localparam int LANES = (CHANNELS > MAX_CH) ? MAX_CH : CHANNELS;

    pix_t [MAX_CH-1:0] top_pix;
    pix_t [MAX_CH-1:0] bottom_pix;
    pix_t [MAX_CH-1:0] lane_res;

    logic stage_valid_reg;
    logic stage_valid_next;
    logic stage_ready;
    logic merge_ready;
    logic load;

    assign top_pix    = {top_blue, top_green, top_red};
    assign bottom_pix = {bottom_blue, bottom_green, bottom_red};

    // The lane stage may take a beat when it is empty or its beat moves on.
    assign stage_ready      = !stage_valid_reg || merge_ready;
    assign in_stall         = !stage_ready;
    assign load             = in_valid && stage_ready;
    assign stage_valid_next = stage_ready ? in_valid : stage_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    genvar ch;
    generate
        for (ch = 0; ch < MAX_CH; ch++)
        begin : g_lane
            if (ch < LANES)
            begin : g_active
                pbu_lane u_lane (
                    .clk  (clk),
                    .load (load),
                    .func (func),
                    .a    (top_pix[ch]),
                    .b    (bottom_pix[ch]),
                    .res  (lane_res[ch])
                );
            end
            else
            begin : g_unused
                // Channels beyond the configured count always read as zero.
                assign lane_res[ch] = '0;
            end
        end
    endgenerate

    pbu_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (stage_valid_reg),
        .lane_res   (lane_res),
        .out_stall  (out_stall),
        .ready      (merge_ready),
        .out_valid  (out_valid),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue)
    );

endmodule

// File: bench/tb_pixel_blend_unit.sv
// Self-checking testbench for the pixel blend unit: directed and random pixel beats.
`timescale 1ns / 100ps

module tb_pixel_blend_unit;

    import pbu_pkg::*;

    // Lane count of the instance under test. The predictor zeroes the channels beyond it.
    localparam int TB_CHANNELS = 3;

    // Mode codes that the package leaves undefined; the block must return black for them.
    localparam logic [2:0] FIRST_UNUSED = 3'd5;
    localparam logic [2:0] LAST_CODE    = 3'd7;

    // One input beat: mode plus top and bottom pixels, channel 0 red, 1 green, 2 blue.
    typedef struct packed {
        logic [2:0]     func;
        pix_t [2:0]     top;
        pix_t [2:0]     bot;
    } pixel_pair_t;

    // One output beat, channel order as above.
    typedef pix_t [2:0] rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] func = 3'd0;
    logic [7:0] top_red = 8'd0;
    logic [7:0] top_green = 8'd0;
    logic [7:0] top_blue = 8'd0;
    logic [7:0] bottom_red = 8'd0;
    logic [7:0] bottom_green = 8'd0;
    logic [7:0] bottom_blue = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    // Pixel pairs still to be offered, and blended pixels still to come back.
    pixel_pair_t pair_q[$];
    rgb_t        blended_q[$];

    // Phase controls: whether the sender inserts gaps and the receiver stalls.
    bit send_gaps = 1'b0;
    bit recv_stalls = 1'b0;

    // Set at a rising edge when the input beat on the bus was taken.
    bit in_fire = 1'b0;

    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int checked_cnt = 0;
    int unused_cnt = 0;
    int err_count = 0;

    string ch_name [3] = '{"out_red", "out_green", "out_blue"};

    pixel_blend_unit #(
        .CHANNELS(TB_CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .top_red(top_red),
        .top_green(top_green),
        .top_blue(top_blue),
        .bottom_red(bottom_red),
        .bottom_green(bottom_green),
        .bottom_blue(bottom_blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Rounded division by 255: floor((x + 127) / 255). No ties exist since 255 is odd.
    function automatic int unsigned div255_round(int unsigned x);
        return (x + 127) / 255;
    endfunction

    // Blend one channel byte of the top layer (a) over the bottom layer (b).
    function automatic pix_t blend_byte(logic [2:0] mode, pix_t a, pix_t b);
        int unsigned ua;
        int unsigned ub;
        int unsigned ia;
        int unsigned ib;
        int unsigned r;
        ua = a;
        ub = b;
        ia = 255 - ua;
        ib = 255 - ub;
        case (mode)
            MODE_MULTIPLY: r = div255_round(ua * ub);
            MODE_SCREEN:   r = 255 - div255_round(ia * ib);
            MODE_SUBTRACT: r = (ua > ub) ? ua - ub : 0;
            MODE_ADD:      r = (ua + ub > 255) ? 255 : ua + ub;
            MODE_OVERLAY:
            begin
                // Dark bottom bytes multiply, light ones screen, both doubled.
                if (ub <= 127)
                    r = div255_round(2 * ua * ub);
                else
                    r = 255 - div255_round(2 * ia * ib);
            end
            default:       r = 0;
        endcase
        return pix_t'(r);
    endfunction

    // Whole-pixel prediction; channels without a lane read as zero.
    function automatic rgb_t blend_pixel(pixel_pair_t p);
        rgb_t px;
        for (int c = 0; c < 3; c++)
            px[c] = (c < TB_CHANNELS) ? blend_byte(p.func, p.top[c], p.bot[c]) : '0;
        return px;
    endfunction

    // Gap or stall length, drawn from three ranges of rising length with falling odds.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Bytes lean toward the corners where rounding and saturation turn over.
    function automatic pix_t rand_byte();
        pix_t corners [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 5)];
        return pix_t'($urandom_range(0, 255));
    endfunction

    task automatic add_pair(logic [2:0] m, pix_t tr, pix_t tg, pix_t tb,
                            pix_t br, pix_t bg, pix_t bb);
        pixel_pair_t p;
        p.func = m;
        p.top = {tb, tg, tr};
        p.bot = {bb, bg, br};
        pair_q.push_back(p);
        pushed_cnt++;
    endtask

    task automatic add_random_pairs(int count);
        logic [2:0] m;
        for (int i = 0; i < count; i++)
        begin
            // Roughly one beat in ten carries an undefined mode code.
            if ($urandom_range(0, 9) == 0)
                m = 3'($urandom_range(FIRST_UNUSED, LAST_CODE));
            else
                m = 3'($urandom_range(MODE_MULTIPLY, MODE_OVERLAY));
            add_pair(m, rand_byte(), rand_byte(), rand_byte(),
                     rand_byte(), rand_byte(), rand_byte());
        end
    endtask

    task automatic wait_all_taken();
        while (accepted_cnt != pushed_cnt)
            @(posedge clk);
    endtask

    // Sender. It works at the falling edge, so the DUT sees stable inputs at the rising
    // edge. A beat stays on the bus, unchanged, until in_fire reports it was taken; only
    // then may the sender idle or move to the next pair. Gaps are chosen without regard
    // to in_stall, so valid never depends on stall.
    int send_wait = 0;

    always @(negedge clk)
    begin
        pixel_pair_t nxt;
        bit drive_valid;
        bit load;
        drive_valid = in_valid;
        load = 1'b0;
        if (rst_n && (!in_valid || in_fire))
        begin
            drive_valid = 1'b0;
            if (send_wait > 0)
                send_wait--;
            else if (pair_q.size() != 0)
            begin
                nxt = pair_q.pop_front();
                load = 1'b1;
                drive_valid = 1'b1;
                // Decide now how long to idle after this beat goes through.
                if (send_gaps && $urandom_range(0, 2) == 0)
                    send_wait = pick_gap();
            end
        end
        in_valid <= drive_valid;
        if (load)
        begin
            func         <= nxt.func;
            top_red      <= nxt.top[0];
            top_green    <= nxt.top[1];
            top_blue     <= nxt.top[2];
            bottom_red   <= nxt.bot[0];
            bottom_green <= nxt.bot[1];
            bottom_blue  <= nxt.bot[2];
        end
    end

    // Receiver back-pressure, also changed at the falling edge. A stall, once started,
    // runs for the whole chosen length, which lets both DUT stages fill up.
    int stall_left = 0;

    always @(negedge clk)
    begin
        bit hold;
        hold = 1'b0;
        if (stall_left > 0)
        begin
            stall_left--;
            hold = 1'b1;
        end
        else if (rst_n && recv_stalls && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap() - 1;
            hold = 1'b1;
        end
        out_stall <= hold;
    end

    // Monitor and scoreboard at the rising edge. A taken output beat is checked against
    // the oldest blended pixel; a taken input beat has its blend predicted from the
    // values on the bus. Each beat passes the lane and output registers first, so the order here does not matter.
    always @(posedge clk)
    begin
        pixel_pair_t seen;
        rgb_t got;
        rgb_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {out_blue, out_green, out_red};
                if (blended_q.size() == 0)
                begin
                    $error("output beat %h%h%h arrived with no pixel pending",
                           out_red, out_green, out_blue);
                    err_count++;
                end
                else
                begin
                    want = blended_q.pop_front();
                    for (int c = 0; c < 3; c++)
                        if (got[c] !== want[c])
                        begin
                            $error("%s: expected %0d, got %0d", ch_name[c], want[c], got[c]);
                            err_count++;
                        end
                    checked_cnt++;
                end
            end
            if (in_valid && !in_stall)
            begin
                seen.func = func;
                seen.top = {top_blue, top_green, top_red};
                seen.bot = {bottom_blue, bottom_green, bottom_red};
                blended_q.push_back(blend_pixel(seen));
                if (func >= FIRST_UNUSED)
                    unused_cnt++;
                accepted_cnt++;
            end
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats at full rate. Each mode sees black against white, mid grey
        // against the overlay threshold on both sides (127 and 128), and full white.
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        for (int m = MODE_MULTIPLY; m <= MODE_OVERLAY; m++)
        begin
            add_pair(3'(m), 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd127);
            add_pair(3'(m), 8'd255, 8'd0, 8'd200, 8'd255, 8'd0, 8'd128);
        end
        // Subtract with equal operands and a bottom above the top; add landing on 255
        // exactly and just past it.
        add_pair(MODE_SUBTRACT, 8'd100, 8'd55, 8'd1, 8'd100, 8'd56, 8'd255);
        add_pair(MODE_ADD, 8'd100, 8'd200, 8'd1, 8'd155, 8'd56, 8'd255);
        // Undefined mode codes must come back black, even for white inputs.
        for (int m = FIRST_UNUSED; m <= LAST_CODE; m++)
            add_pair(3'(m), 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        wait_all_taken();

        // Random beats under changing flow patterns.
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
        add_random_pairs(600);
        wait_all_taken();

        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        add_random_pairs(300);
        wait_all_taken();

        // Back-to-back input against a stalling output keeps both stages full.
        send_gaps = 1'b0;
        recv_stalls = 1'b1;
        add_random_pairs(350);
        wait_all_taken();

        send_gaps = 1'b1;
        recv_stalls = 1'b0;
        add_random_pairs(300);
        wait_all_taken();

        // Drain, then keep watching for any stray output beat.
        while (blended_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d blended pixels over all five modes, %0d with undefined codes,",
                 checked_cnt, unused_cnt);
        $display("with input gaps and output stalls mixed in and full-rate stretches between.");
        if (err_count == 0 && blended_q.size() == 0)
            $display("tb_pixel_blend_unit: done, clean");
        else
            $display("tb_pixel_blend_unit: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("Timed out with %0d pixels still pending.", blended_q.size());
        $display("tb_pixel_blend_unit: done, errors");
        $finish;
    end

endmodule
